// ----- design/assert_macros.svh -----
// assertion macros shared by the design files
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- design/idpt_pkg.sv -----
// shared types and constants of the interval disjoint pair tracker
// no dependencies
`default_nettype none
package idpt_pkg;
	localparam int CAPACITY = 64;
	localparam int COORD_W  = 32;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;

	// command broadcast to every cell of a chain
	typedef struct packed {
		logic   ins;
		logic   rem;
		logic   hit;
		coord_t x;
	} cell_cmd_t;

	// what a cell shows its neighbours
	typedef struct packed {
		coord_t val;
		logic   vld;
		logic   keep;
	} cell_nbr_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} state_t;
endpackage
`default_nettype wire

// ----- design/idpt_if.sv -----
// channel interfaces of the interval disjoint pair tracker
// depends on idpt_pkg
`default_nettype none
interface idpt_in_if;
	logic                    valid;
	logic                    ready;
	logic                    func;
	logic [idpt_pkg::COORD_W-1:0] left_end;
	logic [idpt_pkg::COORD_W-1:0] right_end;
	modport source (output valid, func, left_end, right_end, input ready);
	modport sink   (input valid, func, left_end, right_end, output ready);
endinterface

interface idpt_out_if;
	logic valid;
	logic ready;
	logic disjoint_exists;
	logic insert_dropped;
	modport source (output valid, disjoint_exists, insert_dropped, input ready);
	modport sink   (input valid, disjoint_exists, insert_dropped, output ready);
endinterface
`default_nettype wire

// ----- design/idpt_cell.sv -----
// one cell of a sorted chain: a value, its occupancy bit and the shift logic
// depends on idpt_pkg
`default_nettype none
module idpt_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire idpt_pkg::cell_cmd_t   cmd,
	input  wire idpt_pkg::cell_nbr_t   prev,
	input  wire idpt_pkg::cell_nbr_t   next,
	output idpt_pkg::cell_nbr_t        own,
	output logic                       match
);
	import idpt_pkg::*;

	coord_t val_q;
	logic   vld_q;
	logic   shift;
	logic   take_ins;

	// chain is kept in descending order, so larger values stay put
	assign own.val  = val_q;
	assign own.vld  = vld_q;
	assign own.keep = vld_q && (val_q >= cmd.x);
	assign match    = vld_q && (val_q == cmd.x);
	assign shift    = cmd.rem && cmd.hit && !(vld_q && (val_q > cmd.x));
	assign take_ins = cmd.ins && !own.keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take_ins) begin
			vld_q <= prev.keep ? 1'b1 : prev.vld;
		end else if (shift) begin
			vld_q <= next.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take_ins) begin
			val_q <= prev.keep ? cmd.x : prev.val;
		end else if (shift) begin
			val_q <= next.val;
		end
	end
endmodule
`default_nettype wire

// ----- design/idpt_chain.sv -----
// row of sorted cells holding one multiset, largest value at the head
// depends on idpt_pkg and idpt_cell
`default_nettype none
`include "assert_macros.svh"
module idpt_chain (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ins,
	input  wire logic              rem,
	input  wire idpt_pkg::coord_t  x,
	output idpt_pkg::coord_t       head_val,
	output logic                   head_vld,
	output logic                   full
);
	import idpt_pkg::*;

	cell_nbr_t             nbr [CAPACITY];
	logic [CAPACITY-1:0]   match_vec;
	logic [CAPACITY-1:0]   vld_vec;
	cell_cmd_t             cmd;

	// a removal only shifts when some copy exists
	assign cmd.ins = ins;
	assign cmd.rem = rem;
	assign cmd.x   = x;
	assign cmd.hit = |match_vec;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_nbr_t prev_n;
		cell_nbr_t next_n;
		if (i == 0) begin : g_first
			assign prev_n = '{val: '0, vld: 1'b1, keep: 1'b1};
		end else begin : g_mid
			assign prev_n = nbr[i-1];
		end
		if (i == CAPACITY-1) begin : g_last
			assign next_n = '{val: '0, vld: 1'b0, keep: 1'b0};
		end else begin : g_nxt
			assign next_n = nbr[i+1];
		end
		idpt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.prev  (prev_n),
			.next  (next_n),
			.own   (nbr[i]),
			.match (match_vec[i])
		);
		assign vld_vec[i] = nbr[i].vld;
	end

	assign head_val = nbr[0].val;
	assign head_vld = nbr[0].vld;
	assign full     = nbr[CAPACITY-1].vld;

	// occupied cells always form a prefix of the chain
	`ASSERT_PROP(a_prefix, clk, arst_n, ((vld_vec + 1'b1) & vld_vec) == '0)
	// head is the largest stored value
	`ASSERT_NEVER(a_sorted, clk, arst_n, nbr[1].vld && (nbr[1].val > nbr[0].val))
	// removal of an absent value leaves occupancy unchanged
	`ASSERT_PROP(a_miss, clk, arst_n, (rem && !cmd.hit) |=> $stable(vld_vec))
	// an insert into a full chain is never issued
	`ASSERT_NEVER(a_ins_full, clk, arst_n, ins && full)
endmodule
`default_nettype wire

// ----- design/interval_disjoint_pair_tracker.sv -----
// Interval disjoint pair tracker. Usage:
//   in_ch  (sink): one transfer carries func (0 insert, 1 remove), left_end
//          and right_end. in_ch.ready is high while the block is idle.
//   out_ch (source): one transfer per item with disjoint_exists and
//          insert_dropped.
// Left ends live in one sorted cell chain with the largest value at its
// head; right ends live in a second chain holding their bitwise complements,
// so its head is the smallest right end. Each item updates every cell in
//   the cycle of its transfer (insert shifts smaller values one place toward
// the tail, removal shifts one copy out); the result is formed from the two
// heads in the result step and loaded into the output register once it is
// free. The block takes no new item until the result of the last one is
// loaded into the output register. An insert into a full store is dropped
// and flagged; removal of a value not stored leaves that store unchanged.
// Reset empties both chains and the output register. When the receiver
// stalls the result waits in the output register; the next item is still
// taken and processed, and it waits in the result step until the register
// frees.
// depends on idpt_pkg, idpt_if and idpt_chain
`default_nettype none
`include "assert_macros.svh"
module interval_disjoint_pair_tracker (
	input wire logic   clk,
	input wire logic   arst_n,
	idpt_in_if.sink    in_ch,
	idpt_out_if.source out_ch
);
	import idpt_pkg::*;

	state_t state_q, state_d;
	logic   accept;
	logic   load_out;
	logic   is_ins, is_rem;
	logic   ins_ok;
	coord_t l_head, r_head_n;
	logic   l_vld, r_vld, l_full, r_full;
	logic   dropped_q;
	logic   out_valid_q, disj_q, drop_out_q;
	logic   disj_now;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_ins      = accept && (in_ch.func == FUNC_INSERT);
	assign is_rem      = accept && (in_ch.func == FUNC_REMOVE);
	// both ends go in or neither does
	assign ins_ok      = is_ins && !l_full && !r_full;

	// left chain: largest left end at head
	idpt_chain u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.ins     (ins_ok),
		.rem     (is_rem),
		.x       (in_ch.left_end),
		.head_val(l_head),
		.head_vld(l_vld),
		.full    (l_full)
	);

	// right chain on complemented values: head is the smallest right end
	idpt_chain u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.ins     (ins_ok),
		.rem     (is_rem),
		.x       (~in_ch.right_end),
		.head_val(r_head_n),
		.head_vld(r_vld),
		.full    (r_full)
	);

	assign disj_now = l_vld && r_vld && ((~r_head_n) < l_head);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result step waits until the output register is free
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// drop flag captured at the transfer, before the chains change
	always_ff @(posedge clk) begin
		if (accept) begin
			dropped_q <= is_ins && (l_full || r_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			disj_q     <= disj_now;
			drop_out_q <= dropped_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.disjoint_exists = disj_q;
	assign out_ch.insert_dropped  = drop_out_q;

	// every transfer leads to the result step next cycle
	`ASSERT_PROP(a_acc_res, clk, arst_n, accept |=> (state_q == ST_RESULT))
	// a removal never reports a dropped insert
	`ASSERT_PROP(a_rem_drop, clk, arst_n, is_rem |=> !dropped_q)
	// a result is never loaded over one still waiting
	`ASSERT_NEVER(a_overwrite, clk, arst_n, load_out && out_valid_q && !out_ch.ready)
	// a reported overlap needs both stores occupied
	`ASSERT_NEVER(a_empty, clk, arst_n, disj_now && !(l_vld && r_vld))
endmodule
`default_nettype wire
